@@ hdl/baro_pkg.sv @@
// shared types, widths and constants for the barometer compensation block
package baro_pkg;

  // calibration register indexes
  localparam logic [2:0] REG_PRESS_SENS  = 3'd0;
  localparam logic [2:0] REG_PRESS_OFF   = 3'd1;
  localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [2:0] REG_OFF_TEMP    = 3'd3;
  localparam logic [2:0] REG_REF_TEMP    = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE  = 3'd5;

  // calibration reset values
  localparam logic [15:0] RST_PRESS_SENS = 16'd40127;
  localparam logic [15:0] RST_PRESS_OFF  = 16'd36924;
  localparam logic [15:0] RST_SENS_TEMP  = 16'd23317;
  localparam logic [15:0] RST_OFF_TEMP   = 16'd23282;
  localparam logic [15:0] RST_REF_TEMP   = 16'd33464;
  localparam logic [15:0] RST_TEMP_SLOPE = 16'd28312;

  // serial multiplier geometry
  localparam int MUL_AW = 35;               // signed multiplicand
  localparam int MUL_BW = 24;               // unsigned multiplier, one bit a cycle
  localparam int MUL_PW = MUL_AW + 1 + MUL_BW;
  localparam int MUL_CW = 5;                // iteration counter width

  // calibration words
  typedef struct packed {
    logic [15:0] pressure_sensitivity_coef;
    logic [15:0] pressure_offset_coef;
    logic [15:0] sensitivity_temp_coef;
    logic [15:0] offset_temp_coef;
    logic [15:0] reference_temp_coef;
    logic [15:0] temp_slope_coef;
  } cfg_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  // one result
  typedef struct packed {
    logic signed [14:0] temperature;
    logic [17:0]        pressure;
    logic               from_pressure;
  } res_t;

endpackage

@@ hdl/baro_smul.sv @@
// bit-serial signed by unsigned shift-add multiplier
module baro_smul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [baro_pkg::MUL_CW-1:0]          iters_i,
  input  logic [baro_pkg::MUL_AW-1:0]          a_i,
  input  logic [baro_pkg::MUL_BW-1:0]          b_i,
  output logic                                 done_o,
  output logic [baro_pkg::MUL_PW-1:0]          prod_o
);

  localparam int AW = baro_pkg::MUL_AW;
  localparam int BW = baro_pkg::MUL_BW;
  localparam int PW = baro_pkg::MUL_PW;
  localparam int CW = baro_pkg::MUL_CW;

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] a_q, a_d;
  logic [PW-1:0] p_q, p_d;
  logic [AW:0]   hi_sum;

  // add the multiplicand into the upper half when the low bit is set
  assign hi_sum = p_q[PW-1:BW] + (p_q[0] ? {a_q[AW-1], a_q} : {(AW+1){1'b0}});

  // step control
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = iters_i;
    end else if (run_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == {{(CW-1){1'b0}}, 1'b1}) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // partial product, arithmetic shift right one bit a step
  always_comb begin
    a_d = a_q;
    p_d = p_q;
    if (start_i) begin
      a_d = a_i;
      p_d = {{(AW+1){1'b0}}, b_i};
    end else if (run_q) begin
      p_d = {hi_sum[AW], hi_sum, p_q[BW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ hdl/baro_core.sv @@
// compensation sequencer: temperature, offset, sensitivity and pressure steps
module baro_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  kind_i,
  input  logic [23:0]           raw_sample_i,
  input  baro_pkg::cfg_t        cfg_i,
  input  logic                  ack_i,
  output baro_pkg::stat_t       stat_o,
  output baro_pkg::res_t        res_o
);

  localparam int AW = baro_pkg::MUL_AW;
  localparam int BW = baro_pkg::MUL_BW;
  localparam int PW = baro_pkg::MUL_PW;
  localparam int CW = baro_pkg::MUL_CW;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_POST  = 3'd3;
  localparam logic [2:0] ST_SUB   = 3'd4;
  localparam logic [2:0] ST_CLAMP = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // product being formed
  localparam logic [2:0] PH_TEMP  = 3'd0;
  localparam logic [2:0] PH_OFF   = 3'd1;
  localparam logic [2:0] PH_SENS  = 3'd2;
  localparam logic [2:0] PH_SQ1   = 3'd3;
  localparam logic [2:0] PH_SQ2   = 3'd4;
  localparam logic [2:0] PH_PRESS = 3'd5;

  // iteration counts: calibration words, squared distances, raw samples
  localparam logic [CW-1:0] IT_COEF = CW'(16);
  localparam logic [CW-1:0] IT_SQ   = CW'(13);
  localparam logic [CW-1:0] IT_RAW  = CW'(24);

  localparam logic signed [18:0] TSUM_MIN  = -19'sd4000;
  localparam logic signed [18:0] TSUM_MAX  = 19'sd8500;
  localparam logic signed [14:0] T_CORR1   = 15'sd2000;
  localparam logic signed [14:0] T_CORR2   = -15'sd1500;
  localparam logic [17:0]        PRESS_MAX = 18'h3FFFF;

  logic [2:0]  state_q, state_d;
  logic [2:0]  phase_q, phase_d;
  logic [14:0] t_q, t_d;
  logic [34:0] off_q, off_d;
  logic [33:0] sens_q, sens_d;
  logic [17:0] p_q, p_d;
  logic        kind_q, kind_d;
  logic [23:0] raw_q, raw_d;
  logic [24:0] dt_q, dt_d;
  logic [26:0] sub_off_q, sub_off_d;
  logic [26:0] sub_sens_q, sub_sens_d;
  logic [38:0] a_q, a_d;

  logic          mul_start, mul_done;
  logic [CW-1:0] mul_iters;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;

  logic [24:0] dt_new;
  logic [15:0] x16, y16;
  logic [17:0] temp_s;
  logic [18:0] tsum;
  logic [14:0] t_new;
  logic [40:0] prod41;
  logic [33:0] off_fl;
  logic [32:0] sens_fl;
  logic        off_rnd, sens_rnd;
  logic [34:0] off_new;
  logic [33:0] sens_new;
  logic [25:0] sq_d;
  logic [27:0] m5;
  logic [22:0] sq_e;
  logic [26:0] m7, m11;
  logic [39:0] diff;
  logic [17:0] p_new;

  baro_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .iters_i (mul_iters),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // difference to the reference temperature
  assign dt_new = {1'b0, raw_sample_i} - {1'b0, cfg_i.reference_temp_coef, 8'h00};

  // distances below the two correction thresholds
  assign x16 = 16'd2000 - {t_q[14], t_q};
  assign y16 = ~({t_q[14], t_q} + 16'd1500) + 16'd1;

  // multiplier operands per product
  always_comb begin
    mul_a     = {{(AW-25){dt_q[24]}}, dt_q};
    mul_b     = '0;
    mul_iters = IT_COEF;
    unique case (phase_q)
      PH_TEMP:  mul_b = {8'h00, cfg_i.temp_slope_coef};
      PH_OFF:   mul_b = {8'h00, cfg_i.offset_temp_coef};
      PH_SENS:  mul_b = {8'h00, cfg_i.sensitivity_temp_coef};
      PH_SQ1: begin
        mul_a     = {{(AW-13){1'b0}}, x16[12:0]};
        mul_b     = {11'b0, x16[12:0]};
        mul_iters = IT_SQ;
      end
      PH_SQ2: begin
        mul_a     = {{(AW-12){1'b0}}, y16[11:0]};
        mul_b     = {12'b0, y16[11:0]};
        mul_iters = IT_SQ;
      end
      PH_PRESS: begin
        mul_a     = {{(AW-34){sens_q[33]}}, sens_q};
        mul_b     = raw_q;
        mul_iters = IT_RAW;
      end
      default: mul_b = '0;
    endcase
  end

  // temperature: floor of the product over 2^23, plus 2000, saturated
  assign temp_s = prod[48:31];
  assign tsum   = {temp_s[17], temp_s} + 19'd2000;
  always_comb begin
    if ($signed(tsum) < TSUM_MIN) begin
      t_new = TSUM_MIN[14:0];
    end else if ($signed(tsum) > TSUM_MAX) begin
      t_new = TSUM_MAX[14:0];
    end else begin
      t_new = tsum[14:0];
    end
  end

  // offset and sensitivity, quotients truncated toward zero
  assign prod41   = prod[48:8];
  assign off_fl   = prod41[40:7];
  assign off_rnd  = prod41[40] & (|prod41[6:0]);
  assign sens_fl  = prod41[40:8];
  assign sens_rnd = prod41[40] & (|prod41[7:0]);
  assign off_new  = {3'b0, cfg_i.pressure_offset_coef, 16'h0000} + {off_fl[33], off_fl}
                    + {34'b0, off_rnd};
  assign sens_new = {3'b0, cfg_i.pressure_sensitivity_coef, 15'h0000}
                    + {sens_fl[32], sens_fl} + {33'b0, sens_rnd};

  // second-order terms from the squares
  assign sq_d = prod[36:11];
  assign m5   = {2'b0, sq_d} + {sq_d, 2'b00};
  assign sq_e = prod[33:11];
  assign m7   = {1'b0, sq_e, 3'b000} - {4'b0, sq_e};
  assign m11  = {1'b0, sq_e, 3'b000} + {3'b0, sq_e, 1'b0} + {4'b0, sq_e};

  // pressure: (floor(raw*sens/2^21) - offset) / 2^15, saturated
  assign diff = {a_q[38], a_q} - {{5{off_q[34]}}, off_q};
  always_comb begin
    if (diff[39]) begin
      p_new = '0;
    end else if (|diff[38:33]) begin
      p_new = PRESS_MAX;
    end else begin
      p_new = diff[32:15];
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    t_d        = t_q;
    off_d      = off_q;
    sens_d     = sens_q;
    p_d        = p_q;
    kind_d     = kind_q;
    raw_d      = raw_q;
    dt_d       = dt_q;
    sub_off_d  = sub_off_q;
    sub_sens_d = sub_sens_q;
    a_d        = a_q;
    mul_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_d  = kind_i;
          raw_d   = raw_sample_i;
          dt_d    = dt_new;
          phase_d = kind_i ? PH_PRESS : PH_TEMP;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mul_start = 1'b1;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (mul_done) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        unique case (phase_q)
          PH_TEMP: begin
            t_d     = t_new;
            phase_d = PH_OFF;
            state_d = ST_LOAD;
          end
          PH_OFF: begin
            off_d   = off_new;
            phase_d = PH_SENS;
            state_d = ST_LOAD;
          end
          PH_SENS: begin
            sens_d = sens_new;
            if ($signed(t_q) < T_CORR1) begin
              phase_d = PH_SQ1;
              state_d = ST_LOAD;
            end else begin
              state_d = ST_DONE;
            end
          end
          PH_SQ1: begin
            sub_off_d  = m5[27:1];
            sub_sens_d = {1'b0, m5[27:2]};
            state_d    = ST_SUB;
          end
          PH_SQ2: begin
            sub_off_d  = m7;
            sub_sens_d = {1'b0, m11[26:1]};
            state_d    = ST_SUB;
          end
          PH_PRESS: begin
            a_d     = prod[59:21];
            state_d = ST_CLAMP;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SUB: begin
        off_d  = off_q - {8'b0, sub_off_q};
        sens_d = sens_q - {7'b0, sub_sens_q};
        if (phase_q == PH_SQ1 && $signed(t_q) < T_CORR2) begin
          phase_d = PH_SQ2;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLAMP: begin
        p_d     = p_new;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_TEMP;
      t_q     <= '0;
      off_q   <= '0;
      sens_q  <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      t_q     <= t_d;
      off_q   <= off_d;
      sens_q  <= sens_d;
      p_q     <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    raw_q      <= raw_d;
    dt_q       <= dt_d;
    sub_off_q  <= sub_off_d;
    sub_sens_q <= sub_sens_d;
    a_q        <= a_d;
  end

  assign stat_o.busy          = (state_q != ST_IDLE);
  assign stat_o.done          = (state_q == ST_DONE);
  assign res_o.temperature    = t_q;
  assign res_o.pressure       = p_q;
  assign res_o.from_pressure  = kind_q;

endmodule

@@ hdl/barometer_compensation_top.sv @@
// top level: calibration registers, compensation sequencer and result register
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_stall_o    kind_i, raw_sample_i
//   out      result     out_valid_o / out_stall_i  temperature_o, pressure_o, from_pressure_o
//   cfg      write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one request at a time, held off until the previous result is handed over; a temperature
// request forms the temperature, offset and sensitivity products and, when cold, one or two
// squares, a pressure request one product, on a bit-serial multiplier (one multiplier bit a cycle)
// reset clears the control state, the kept temperature, offset, sensitivity and pressure
// and loads the default calibration words
// a finished result waits in the output register; the next request is taken meanwhile,
// and the sequencer holds its own result only while that register is full and stalled
module barometer_compensation_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [23:0]        raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] temperature_o,
  output logic [17:0]        pressure_o,
  output logic               from_pressure_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  baro_pkg::cfg_t  cfg_q, cfg_d;
  baro_pkg::stat_t stat;
  baro_pkg::res_t  res;
  baro_pkg::res_t  out_q;
  logic            out_valid_q, out_valid_d;
  logic            start, ack, slot_free;

  // calibration register writes, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        baro_pkg::REG_PRESS_SENS: cfg_d.pressure_sensitivity_coef = cfg_data_i;
        baro_pkg::REG_PRESS_OFF:  cfg_d.pressure_offset_coef      = cfg_data_i;
        baro_pkg::REG_SENS_TEMP:  cfg_d.sensitivity_temp_coef     = cfg_data_i;
        baro_pkg::REG_OFF_TEMP:   cfg_d.offset_temp_coef          = cfg_data_i;
        baro_pkg::REG_REF_TEMP:   cfg_d.reference_temp_coef       = cfg_data_i;
        baro_pkg::REG_TEMP_SLOPE: cfg_d.temp_slope_coef           = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure_sensitivity_coef <= baro_pkg::RST_PRESS_SENS;
      cfg_q.pressure_offset_coef      <= baro_pkg::RST_PRESS_OFF;
      cfg_q.sensitivity_temp_coef     <= baro_pkg::RST_SENS_TEMP;
      cfg_q.offset_temp_coef          <= baro_pkg::RST_OFF_TEMP;
      cfg_q.reference_temp_coef       <= baro_pkg::RST_REF_TEMP;
      cfg_q.temp_slope_coef           <= baro_pkg::RST_TEMP_SLOPE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // request handshake
  assign in_stall_o = stat.busy;
  assign start      = in_valid_i & ~stat.busy;

  baro_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .kind_i       (kind_i),
    .raw_sample_i (raw_sample_i),
    .cfg_i        (cfg_q),
    .ack_i        (ack),
    .stat_o       (stat),
    .res_o        (res)
  );

  // output register
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign ack       = stat.done & slot_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ack) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign temperature_o   = out_q.temperature;
  assign pressure_o      = out_q.pressure;
  assign from_pressure_o = out_q.from_pressure;

endmodule

@@ dv/barometer_compensation_top_test.sv @@
// self-checking testbench for the barometer compensation top level
`timescale 1ns / 1ps

module barometer_compensation_top_test;

  // request kinds
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  localparam int RX_HOLD_CYCLES = 600;
  localparam longint TEMP_FLOOR = -4000;
  localparam longint TEMP_CEIL  = 8500;
  localparam longint PRESS_CEIL = 262143;

  typedef enum int {CAL_RESET, CAL_ZERO, CAL_FULL, CAL_RANDOM, CAL_NEAR} cal_pick_e;

  typedef struct packed {
    logic        kind;
    logic [23:0] raw;
  } conversion_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = KIND_TEMP;
  logic [23:0]        raw_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [14:0] temperature_o;
  logic [17:0]        pressure_o;
  logic               from_pressure_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  // calibration and kept compensation state as the block should hold them
  baro_pkg::cfg_t     cal;
  logic signed [14:0] kept_temp = '0;
  longint             kept_offset = 0;
  longint             kept_sens = 0;
  logic [17:0]        kept_press = '0;

  conversion_t    pending_requests[$];
  baro_pkg::res_t expected_readings[$];
  conversion_t    next_req;
  baro_pkg::res_t want_reading;
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          rx_hold_asked = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;

  barometer_compensation_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .temperature_o   (temperature_o),
    .pressure_o      (pressure_o),
    .from_pressure_o (from_pressure_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // compensation of one conversion, updating the kept state
  function automatic baro_pkg::res_t compensate_conversion(logic kind, logic [23:0] raw);
    longint raw_l, d_t, t, off2, sens2, sq, a, p;
    baro_pkg::res_t r;
    raw_l = longint'({40'd0, raw});
    if (kind == KIND_TEMP) begin
      d_t = raw_l - (longint'({48'd0, cal.reference_temp_coef}) <<< 8);
      t = 2000 + ((d_t * longint'({48'd0, cal.temp_slope_coef})) >>> 23);
      if (t < TEMP_FLOOR) t = TEMP_FLOOR;
      if (t > TEMP_CEIL) t = TEMP_CEIL;
      off2 = 0;
      sens2 = 0;
      // second-order correction when cold, more when very cold
      if (t < 2000) begin
        sq = (t - 2000) * (t - 2000);
        off2 = (5 * sq) / 2;
        sens2 = (5 * sq) / 4;
        if (t < -1500) begin
          sq = (t + 1500) * (t + 1500);
          off2 += 7 * sq;
          sens2 += (11 * sq) / 2;
        end
      end
      kept_temp = t[14:0];
      kept_offset = (longint'({48'd0, cal.pressure_offset_coef}) <<< 16)
                    + (d_t * longint'({48'd0, cal.offset_temp_coef})) / 128 - off2;
      kept_sens = (longint'({48'd0, cal.pressure_sensitivity_coef}) <<< 15)
                  + (d_t * longint'({48'd0, cal.sensitivity_temp_coef})) / 256 - sens2;
    end else begin
      a = (raw_l * kept_sens) >>> 21;
      p = (a - kept_offset) >>> 15;
      if (p < 0) p = 0;
      if (p > PRESS_CEIL) p = PRESS_CEIL;
      kept_press = p[17:0];
    end
    r.temperature = kept_temp;
    r.pressure = kept_press;
    r.from_pressure = kind;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // request driver: predicts on acceptance, then offers the next pending request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= KIND_TEMP;
      raw_sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_readings.push_back(compensate_conversion(kind_i, raw_sample_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= next_req.kind;
          raw_sample_i <= next_req.raw;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_seen <= 0;
      rx_hold_left <= 0;
    end else if (rx_hold_asked != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_asked;
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result: temp %0d press %0d from_pressure %0b",
                                    temperature_o, pressure_o, from_pressure_o));
        end else begin
          want_reading = expected_readings.pop_front();
          if (temperature_o !== want_reading.temperature)
            report_mismatch($sformatf("temperature %0d, expected %0d",
                                      temperature_o, want_reading.temperature));
          if (pressure_o !== want_reading.pressure)
            report_mismatch($sformatf("pressure %0d, expected %0d",
                                      pressure_o, want_reading.pressure));
          if (from_pressure_o !== want_reading.from_pressure)
            report_mismatch($sformatf("from_pressure %0b, expected %0b",
                                      from_pressure_o, want_reading.from_pressure));
        end
      end
      out_stall_i <= (rx_hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic add_request(input logic kind, input logic [23:0] raw);
    conversion_t c;
    c.kind = kind;
    c.raw = raw;
    pending_requests.push_back(c);
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_readings.size() != 0);
  endtask

  task automatic set_idling(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic baro_pkg::cfg_t pick_calibration(cal_pick_e pick);
    baro_pkg::cfg_t c;
    c = '{baro_pkg::RST_PRESS_SENS, baro_pkg::RST_PRESS_OFF, baro_pkg::RST_SENS_TEMP,
          baro_pkg::RST_OFF_TEMP, baro_pkg::RST_REF_TEMP, baro_pkg::RST_TEMP_SLOPE};
    case (pick)
      CAL_ZERO:   c = '0;
      CAL_FULL:   c = '1;
      CAL_RANDOM: c = {$urandom, $urandom, $urandom};
      CAL_NEAR:   c ^= {$urandom, $urandom, $urandom} & {6{16'h0FFF}};
      default:    c = c;
    endcase
    return c;
  endfunction

  // writes all six words plus one ignored write beyond the last index
  task automatic write_calibration(input baro_pkg::cfg_t c);
    logic [15:0] words [6];
    words[baro_pkg::REG_PRESS_SENS] = c.pressure_sensitivity_coef;
    words[baro_pkg::REG_PRESS_OFF]  = c.pressure_offset_coef;
    words[baro_pkg::REG_SENS_TEMP]  = c.sensitivity_temp_coef;
    words[baro_pkg::REG_OFF_TEMP]   = c.offset_temp_coef;
    words[baro_pkg::REG_REF_TEMP]   = c.reference_temp_coef;
    words[baro_pkg::REG_TEMP_SLOPE] = c.temp_slope_coef;
    for (int i = baro_pkg::REG_PRESS_SENS; i <= baro_pkg::REG_TEMP_SLOPE; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i <= words[i];
    end
    @(posedge clk_i);
    cfg_index_i <= 3'(baro_pkg::REG_TEMP_SLOPE + 1 + $urandom_range(1));
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cal = c;
  endtask

  // raw temperature spread around the reference point at random magnitudes, sometimes fully random
  function automatic logic [23:0] random_temp_raw();
    longint v;
    longint delta;
    if ($urandom_range(4) == 0) return 24'($urandom);
    delta = longint'($urandom_range(32'(1) << $urandom_range(23), 0));
    if ($urandom_range(1) == 1) delta = -delta;
    v = (longint'({48'd0, cal.reference_temp_coef}) <<< 8) + delta;
    if (v < 0) v = 0;
    if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
    return v[23:0];
  endfunction

  function automatic logic [23:0] random_pressure_raw();
    case ($urandom_range(5))
      0:       return 24'($urandom_range(4095));
      1:       return 24'hFF_FFFF - 24'($urandom_range(4095));
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly a temperature request then a few pressures, some noise
  task automatic add_random_requests(input int count);
    int n = 0;
    int k;
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        k = $urandom_range(3, 1);
        add_request(KIND_TEMP, random_temp_raw());
        repeat (k) add_request(KIND_PRESS, random_pressure_raw());
        n += k + 1;
      end else begin
        add_request(1'($urandom_range(1)), 24'($urandom));
        n++;
      end
    end
  endtask

  task automatic random_phase(input cal_pick_e pick, input int count);
    wait_drained();
    write_calibration(pick_calibration(pick));
    @(negedge clk_i);
    add_random_requests(count);
  endtask

  // stimulus sequence and end of run
  initial begin
    cal = pick_calibration(CAL_RESET);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_idling(16, 64);

    // directed, reset calibration
    add_request(KIND_PRESS, 24'd9085466);   // pressure before any temperature
    add_request(KIND_TEMP,  24'd8566784);   // exactly 20.00 degrees
    add_request(KIND_PRESS, 24'd9085466);
    add_request(KIND_TEMP,  24'd8566783);   // just below 20.00
    add_request(KIND_PRESS, 24'd0);
    add_request(KIND_PRESS, 24'hFF_FFFF);
    add_request(KIND_TEMP,  24'd7974204);   // near zero degrees
    add_request(KIND_PRESS, 24'd9085466);
    add_request(KIND_TEMP,  24'd7529766);   // exactly -15.00
    add_request(KIND_PRESS, 24'd9085466);
    add_request(KIND_TEMP,  24'd7233478);   // well below -15.00
    add_request(KIND_TEMP,  24'd0);         // saturates cold
    add_request(KIND_PRESS, 24'd9085466);
    add_request(KIND_TEMP,  24'hFF_FFFF);   // saturates hot
    add_request(KIND_PRESS, 24'hFF_FFFF);
    add_request(KIND_TEMP,  24'd9455657);
    add_request(KIND_PRESS, 24'd9085466);

    // directed, calibration at both extremes
    wait_drained();
    write_calibration(pick_calibration(CAL_ZERO));
    @(negedge clk_i);
    add_request(KIND_TEMP,  24'hFF_FFFF);
    add_request(KIND_PRESS, 24'hFF_FFFF);
    add_request(KIND_PRESS, 24'd0);
    wait_drained();
    write_calibration(pick_calibration(CAL_FULL));
    @(negedge clk_i);
    add_request(KIND_TEMP,  24'd0);
    add_request(KIND_PRESS, 24'hFF_FFFF);
    add_request(KIND_TEMP,  24'hFF_FFFF);
    add_request(KIND_PRESS, 24'd1);

    // random, sender idles lightly, receiver heavily
    random_phase(CAL_RESET, 130);
    random_phase(CAL_RANDOM, 120);

    // random, the other way round
    wait_drained();
    set_idling(64, 16);
    random_phase(CAL_FULL, 60);
    random_phase(CAL_NEAR, 190);

    // random, no idling, with one long receiver hold-off at the start
    wait_drained();
    set_idling(0, 0);
    wait_drained();
    write_calibration(pick_calibration(CAL_NEAR));
    @(negedge clk_i);
    rx_hold_asked++;
    add_random_requests(200);
    random_phase(CAL_ZERO, 25);
    random_phase(CAL_RANDOM, 25);

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/baro_pkg.sv
hdl/baro_smul.sv
hdl/baro_core.sv
hdl/barometer_compensation_top.sv
dv/barometer_compensation_top_test.sv
